>>> rtl/fir_df_pkg.sv
// Shared constants and types for the direct-form FIR filter.
// No dependencies; fir_df_mac and the top level refer to it by scoped names.
package fir_df_pkg;

   // Field widths of the request, response and register
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int PROD_W     = SAMPLE_W + COEF_W;

   // Sum of Q4.30 products back to Q1.15: drop fifteen fraction bits, round half up
   localparam int ROUND_SHIFT = 15;

   localparam int DEFAULT_TAPS = 64;

   localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = COUNT_W'(64);

   // Request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // Sequencer to datapath control
   typedef struct packed {
      logic start;   // clear the accumulator for a new sample
      logic issue;   // memory reads for one tap are presented this cycle
      logic last;    // this tap is the final one of the sum
   } mac_ctrl_type;

   // Datapath to sequencer status
   typedef struct packed {
      logic done;       // rounded result is ready
      logic saturated;  // result was clipped
   } mac_status_type;

endpackage

>>> rtl/fir_df_ram.sv
// Simple dual-port synchronous memory: one write port, one registered read port.
// Depends on nothing; used for the sample history and the tap weights.
module fir_df_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, and read through an output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fir_df_mac.sv
// Multiply-accumulate datapath: product register, wide accumulator, round and saturate.
// Depends on fir_df_pkg for widths and the control and status structs.
module fir_df_mac #(
   parameter int TAPS = fir_df_pkg::DEFAULT_TAPS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fir_df_pkg::mac_ctrl_type               ctrl,
   input  logic signed [fir_df_pkg::COEF_W-1:0]   coef,
   input  logic signed [fir_df_pkg::SAMPLE_W-1:0] hist,
   output logic signed [fir_df_pkg::SAMPLE_W-1:0] filtered,
   output fir_df_pkg::mac_status_type             status
);

   localparam int ACC_W = fir_df_pkg::PROD_W + $clog2(TAPS);
   localparam int Q_W   = ACC_W + 1 - fir_df_pkg::ROUND_SHIFT;

   logic                                   prod_vld_ff, prod_last_ff;
   logic                                   acc_vld_ff, acc_last_ff;
   logic                                   round_ff;
   logic                                   done_ff;
   logic signed [fir_df_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]                acc_ff;
   logic signed [ACC_W:0]                  biased;
   logic signed [Q_W-1:0]                  quot;
   logic signed [fir_df_pkg::SAMPLE_W-1:0] res_ff, res_in;
   logic                                   sat_ff, sat_in;

   // advance the valid and last markers alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         acc_vld_ff   <= 1'b0;
         acc_last_ff  <= 1'b0;
         round_ff     <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         prod_vld_ff  <= ctrl.issue;
         prod_last_ff <= ctrl.last;
         acc_vld_ff   <= prod_vld_ff;
         acc_last_ff  <= prod_last_ff;
         round_ff     <= acc_vld_ff & acc_last_ff;
         done_ff      <= round_ff;
      end
   end

   // multiply the operands that the memories return
   assign prod_in = coef * hist;

   // round half up, then clip to Q1.15
   always_comb begin
      biased = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(16384);
      quot   = biased[ACC_W:fir_df_pkg::ROUND_SHIFT];
      sat_in = 1'b0;
      res_in = quot[fir_df_pkg::SAMPLE_W-1:0];
      if (quot > Q_W'(32767)) begin
         res_in = 16'sh7FFF;
         sat_in = 1'b1;
      end else if (quot < -Q_W'(32768)) begin
         res_in = 16'sh8000;
         sat_in = 1'b1;
      end
   end

   // product, accumulator and result registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.start) begin
         acc_ff <= '0;
      end else if (acc_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (round_ff) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign filtered         = res_ff;
   assign status.done      = done_ff;
   assign status.saturated = sat_ff;

endmodule

>>> rtl/fir_filter_direct_form.sv
// Top level of the direct-form FIR filter: sequencer, both memories, MAC datapath, response register.
// Depends on fir_df_pkg, fir_df_ram and fir_df_mac.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+----------------------------------------------
//   req_     | in        | req_valid/stall   | kind, sample, coef_index, coef_value
//   rsp_     | out       | rsp_valid/stall   | filtered, saturated
//   csr_     | in        | csr_valid/ready   | tap_count
//
// A sample request makes one memory read pair per tap, for the tap count clamped to
// one..TAPS, then passes the product, accumulate and round stages. After reset a clearing
// pass zeroes both memories; requests stall throughout it. The response register lets the
// next request enter while the last result waits under rsp_stall; a finished sum waits in
// the datapath if it is still full.
module fir_filter_direct_form #(
   parameter int TAPS = fir_df_pkg::DEFAULT_TAPS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic signed [fir_df_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [fir_df_pkg::INDEX_W-1:0]         req_coef_index,
   input  logic signed [fir_df_pkg::COEF_W-1:0]   req_coef_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fir_df_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                   rsp_saturated,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fir_df_pkg::COUNT_W-1:0]         csr_tap_count
);

   localparam int IDX_W = $clog2(TAPS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TAPS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type                              state_ff, state_in;
   logic [IDX_W-1:0]                       newest_ff, newest_in;
   logic [IDX_W-1:0]                       slot_ff, slot_in;
   logic [IDX_W-1:0]                       tap_ff, tap_in;
   logic [IDX_W-1:0]                       last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]                       clr_ff, clr_in;
   logic [fir_df_pkg::COUNT_W-1:0]         tap_count_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [fir_df_pkg::SAMPLE_W-1:0] rsp_filtered_ff;
   logic                                   rsp_saturated_ff;

   logic                                   accept;
   logic                                   rsp_load;
   logic [IDX_W-1:0]                       new_slot;
   logic [IDX_W-1:0]                       count_last;
   logic                                   hist_we, coef_we;
   logic [IDX_W-1:0]                       hist_waddr, coef_waddr;
   logic [fir_df_pkg::SAMPLE_W-1:0]        hist_wdata, hist_rdata;
   logic [fir_df_pkg::COEF_W-1:0]          coef_wdata, coef_rdata;
   fir_df_pkg::mac_ctrl_type               mac_ctrl;
   fir_df_pkg::mac_status_type             mac_status;
   logic signed [fir_df_pkg::SAMPLE_W-1:0] mac_filtered;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // step the newest slot back by one, wrapping at the bottom
   assign new_slot = (newest_ff == '0) ? LAST_SLOT : newest_ff - 1'b1;

   // clamp the tap count to one..TAPS and turn it into the last tap index
   always_comb begin
      if (tap_count_ff == '0) begin
         count_last = '0;
      end else if (32'(tap_count_ff) > TAPS) begin
         count_last = LAST_SLOT;
      end else begin
         count_last = IDX_W'(tap_count_ff - 1'b1);
      end
   end

   // load the response register once it is empty or being drained
   assign rsp_load = (state_ff == ST_OUT) & (~rsp_valid_ff | ~rsp_stall);

   // sequencer and memory write ports
   always_comb begin
      state_in    = state_ff;
      newest_in   = newest_ff;
      slot_in     = slot_ff;
      tap_in      = tap_ff;
      last_idx_in = last_idx_ff;
      clr_in      = clr_ff;
      hist_we     = 1'b0;
      hist_waddr  = new_slot;
      hist_wdata  = req_sample;
      coef_we     = 1'b0;
      coef_waddr  = IDX_W'(req_coef_index);
      coef_wdata  = req_coef_value;
      mac_ctrl    = '0;
      case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
            coef_we    = 1'b1;
            coef_waddr = clr_ff;
            coef_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == fir_df_pkg::KIND_COEF) begin
                  // drop writes to taps that do not exist
                  coef_we = (32'(req_coef_index) < TAPS);
               end else begin
                  hist_we        = 1'b1;
                  newest_in      = new_slot;
                  slot_in        = new_slot;
                  tap_in         = '0;
                  last_idx_in    = count_last;
                  mac_ctrl.start = 1'b1;
                  state_in       = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.last  = (tap_ff == last_idx_ff);
            tap_in         = tap_ff + 1'b1;
            slot_in        = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            if (tap_ff == last_idx_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (mac_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // response valid: set on load, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         newest_ff    <= '0;
         tap_count_ff <= fir_df_pkg::TAP_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         newest_ff    <= newest_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid & csr_ready) begin
            tap_count_ff <= csr_tap_count;
         end
      end
   end

   // address and response payload registers
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      tap_ff      <= tap_in;
      last_idx_ff <= last_idx_in;
      if (rsp_load) begin
         rsp_filtered_ff  <= mac_filtered;
         rsp_saturated_ff <= mac_status.saturated;
      end
   end

   fir_df_ram #(
      .DEPTH (TAPS),
      .WIDTH (fir_df_pkg::SAMPLE_W)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (slot_ff),
      .rdata (hist_rdata)
   );

   fir_df_ram #(
      .DEPTH (TAPS),
      .WIDTH (fir_df_pkg::COEF_W)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (tap_ff),
      .rdata (coef_rdata)
   );

   fir_df_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .coef     (coef_rdata),
      .hist     (hist_rdata),
      .filtered (mac_filtered),
      .status   (mac_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // a new response only ever comes from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response appeared outside the output state");

   // the datapath finishes only while the sequencer waits for it
   a_done_in_flush: assert property (@(posedge clock) disable iff (reset)
      mac_status.done |-> (state_ff == ST_FLUSH))
      else $error("datapath result arrived while sequencer was not waiting");

   // the tap index never runs past the clamped count
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (tap_ff <= last_idx_ff))
      else $error("tap index ran past the last tap");

   // no request is taken during the clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request accepted while memories were being cleared");

endmodule
